[hdl/atc_pkg.sv]
`default_nettype none
package atc_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ROTATE    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCALE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd2;

    // multiplier operands, product and accumulator widths
    localparam int OP_W   = DATA_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 1 - FRAC_BITS;

    // angle handling
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam int RED_W        = 34;
    localparam int CNT_W        = 5;

    localparam longint CORDIC_GAIN = 64'd652032874;
    localparam longint FULL_DEG    = 64'd360 << FRAC_BITS;
    localparam longint QUARTER_DEG = 64'd90 << ANG_FRAC;
    localparam longint HALF_RANGE  = 64'd1 << (DATA_W - 1);
    localparam longint WRAP_OFS    = HALF_RANGE % FULL_DEG;
    localparam longint ONE_FIX     = 64'd1 << FRAC_BITS;

    // number of restoring steps to bring an offset 32-bit angle below one turn
    function automatic int red_steps();
        int n;
        n = 1;
        for (int i = 0; i < 40; i++) begin
            if ((FULL_DEG << n) <= 64'hFFFF_FFFF) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int RED_STEPS = red_steps();

    // arctangent of 2^-i in degrees, Q24
    function automatic logic [Z_W-1:0] atan_deg(input logic [CNT_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(754974720);
            5'd1:    v = Z_W'(445687602);
            5'd2:    v = Z_W'(235489088);
            5'd3:    v = Z_W'(119537938);
            5'd4:    v = Z_W'(60000934);
            5'd5:    v = Z_W'(30029717);
            5'd6:    v = Z_W'(15018523);
            5'd7:    v = Z_W'(7509720);
            5'd8:    v = Z_W'(3754917);
            5'd9:    v = Z_W'(1877466);
            5'd10:   v = Z_W'(938734);
            5'd11:   v = Z_W'(469367);
            5'd12:   v = Z_W'(234684);
            5'd13:   v = Z_W'(117342);
            5'd14:   v = Z_W'(58671);
            5'd15:   v = Z_W'(29335);
            5'd16:   v = Z_W'(14668);
            5'd17:   v = Z_W'(7334);
            5'd18:   v = Z_W'(3667);
            5'd19:   v = Z_W'(1833);
            5'd20:   v = Z_W'(917);
            5'd21:   v = Z_W'(458);
            5'd22:   v = Z_W'(229);
            5'd23:   v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/atc_rmul.sv]
`default_nettype none
module atc_rmul (
    input  wire logic                              clk,
    input  wire logic signed [atc_pkg::OP_W-1:0]   a,
    input  wire logic signed [atc_pkg::OP_W-1:0]   b,
    output logic signed [atc_pkg::ACC_W-1:0]       rnd
);

    logic signed [atc_pkg::PROD_W-1:0] prod_reg;
    logic signed [atc_pkg::PROD_W-1:0] sum;
    logic signed [atc_pkg::PROD_W-1:0] shifted;

    // registered full-width product
    always_ff @(posedge clk)
    begin
        prod_reg <= atc_pkg::PROD_W'(a) * atc_pkg::PROD_W'(b);
    end

    // round half up to the fixed-point grid
    always_comb
    begin
        sum     = prod_reg + (atc_pkg::PROD_W'(1) <<< (atc_pkg::FRAC_BITS - 1));
        shifted = sum >>> atc_pkg::FRAC_BITS;
        rnd     = shifted[atc_pkg::ACC_W-1:0];
    end

endmodule
`default_nettype wire

[hdl/affine_transform_accumulator.sv]
//  channel | signals                                                     | direction
//  request | in_valid, in_ready, func, angle_deg, scale_factor,         | in
//          | center_x, center_y, shift_x, shift_y                        |
//  result  | out_valid, out_ready, m_xx, m_xy, m_yx, m_yy, m_tx, m_ty    | out
//
//  one request at a time; in_ready is low from accept until the result is taken
//  rotate: angle reduction, quadrant mapping, 24 cordic steps,
//  rounding, 16 multiplies through the one shared multiplier, drain, clamp, result
//  scale and translate: 16 multiplies, drain, clamp, result
//  reset loads the identity matrix; a stalled result holds until taken
`default_nettype none
module affine_transform_accumulator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [31:0] angle_deg,
    input  wire logic signed [31:0] scale_factor,
    input  wire logic signed [31:0] center_x,
    input  wire logic signed [31:0] center_y,
    input  wire logic signed [31:0] shift_x,
    input  wire logic signed [31:0] shift_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      m_xx,
    output logic signed [31:0]      m_xy,
    output logic signed [31:0]      m_yx,
    output logic signed [31:0]      m_yy,
    output logic signed [31:0]      m_tx,
    output logic signed [31:0]      m_ty
);

    localparam int OP_W  = atc_pkg::OP_W;
    localparam int ACC_W = atc_pkg::ACC_W;
    localparam int XY_W  = atc_pkg::XY_W;
    localparam int Z_W   = atc_pkg::Z_W;
    localparam int RED_W = atc_pkg::RED_W;
    localparam int CNT_W = atc_pkg::CNT_W;
    localparam int DW    = atc_pkg::DATA_W;
    localparam int FB    = atc_pkg::FRAC_BITS;

    localparam logic [RED_W-1:0] FULL_R  = RED_W'(atc_pkg::FULL_DEG);
    localparam logic [RED_W-1:0] OFS_R   = RED_W'(atc_pkg::WRAP_OFS);
    localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(atc_pkg::QUARTER_DEG);
    localparam logic signed [OP_W-1:0] ONE_OP   = OP_W'(atc_pkg::ONE_FIX);
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(64'd1 << (DW - 1));
    localparam logic [CNT_W-1:0] RED_LAST   = CNT_W'(atc_pkg::RED_STEPS - 1);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(atc_pkg::CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] MAC_LAST   = CNT_W'(15);
    localparam logic [2:0] DST_T4 = 3'd6;
    localparam logic [2:0] DST_T5 = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_REDUCE, S_WRAP, S_QUAD, S_CORDIC, S_ROUND, S_MAC, S_DRAIN, S_SAT, S_OUT
    } state_t;

    state_t state_reg;
    logic out_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RED_W-1:0] rem_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [1:0] q_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [DW-1:0] cx_reg, cy_reg;
    logic signed [OP_W-1:0] t_reg [4];
    logic signed [OP_W-1:0] omc_reg, sn_reg;
    logic signed [ACC_W-1:0] acc_reg [8];
    logic signed [DW-1:0] mat_reg [6];
    logic pend_valid_reg, pend_sub_reg;
    logic [2:0] pend_dst_reg;

    logic signed [OP_W-1:0] mul_a, mul_b;
    logic [2:0] mul_dst;
    logic mul_sub;
    logic signed [ACC_W-1:0] rnd;
    logic [RED_W-1:0] red_sub;
    logic [RED_W-1:0] wrapped;
    logic signed [XY_W-1:0] xr, yr;
    logic signed [OP_W-1:0] c_fix, s_fix, cs_fix, sn_fix;
    logic signed [ACC_W-1:0] n4, n5;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign m_xx = mat_reg[0];
    assign m_xy = mat_reg[1];
    assign m_yx = mat_reg[2];
    assign m_yy = mat_reg[3];
    assign m_tx = mat_reg[4];
    assign m_ty = mat_reg[5];

    // shared rounding multiplier
    atc_rmul u_rmul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .rnd (rnd)
    );

    // multiply schedule: translation terms of t, then all six matrix entries composed with the 2x2 of t
    always_comb
    begin
        mul_a   = omc_reg;
        mul_b   = OP_W'(cx_reg);
        mul_dst = DST_T4;
        mul_sub = 1'b0;
        case (cnt_reg[3:0])
            4'd0:  begin mul_a = omc_reg; mul_b = OP_W'(cx_reg); mul_dst = DST_T4; end
            4'd1:  begin mul_a = sn_reg;  mul_b = OP_W'(cy_reg); mul_dst = DST_T4; end
            4'd2:  begin mul_a = omc_reg; mul_b = OP_W'(cy_reg); mul_dst = DST_T5; end
            4'd3:  begin mul_a = sn_reg;  mul_b = OP_W'(cx_reg); mul_dst = DST_T5;
                         mul_sub = 1'b1; end
            4'd4:  begin mul_a = OP_W'(mat_reg[0]); mul_b = t_reg[0]; mul_dst = 3'd0; end
            4'd5:  begin mul_a = OP_W'(mat_reg[1]); mul_b = t_reg[2]; mul_dst = 3'd0; end
            4'd6:  begin mul_a = OP_W'(mat_reg[0]); mul_b = t_reg[1]; mul_dst = 3'd1; end
            4'd7:  begin mul_a = OP_W'(mat_reg[1]); mul_b = t_reg[3]; mul_dst = 3'd1; end
            4'd8:  begin mul_a = OP_W'(mat_reg[2]); mul_b = t_reg[0]; mul_dst = 3'd2; end
            4'd9:  begin mul_a = OP_W'(mat_reg[3]); mul_b = t_reg[2]; mul_dst = 3'd2; end
            4'd10: begin mul_a = OP_W'(mat_reg[2]); mul_b = t_reg[1]; mul_dst = 3'd3; end
            4'd11: begin mul_a = OP_W'(mat_reg[3]); mul_b = t_reg[3]; mul_dst = 3'd3; end
            4'd12: begin mul_a = OP_W'(mat_reg[4]); mul_b = t_reg[0]; mul_dst = 3'd4; end
            4'd13: begin mul_a = OP_W'(mat_reg[5]); mul_b = t_reg[2]; mul_dst = 3'd4; end
            4'd14: begin mul_a = OP_W'(mat_reg[4]); mul_b = t_reg[1]; mul_dst = 3'd5; end
            default: begin mul_a = OP_W'(mat_reg[5]); mul_b = t_reg[3]; mul_dst = 3'd5; end
        endcase
    end

    // angle reduction, cordic rounding, quadrant mapping and translation sums
    always_comb
    begin
        red_sub = FULL_R << cnt_reg;
        if (rem_reg >= OFS_R)
            wrapped = rem_reg - OFS_R;
        else
            wrapped = rem_reg + FULL_R - OFS_R;
        xr = (x_reg + (XY_W'(1) <<< (29 - FB))) >>> (30 - FB);
        yr = (y_reg + (XY_W'(1) <<< (29 - FB))) >>> (30 - FB);
        c_fix = OP_W'(xr);
        s_fix = OP_W'(yr);
        case (q_reg)
            2'd0:    begin cs_fix = c_fix;  sn_fix = s_fix;  end
            2'd1:    begin cs_fix = -s_fix; sn_fix = c_fix;  end
            2'd2:    begin cs_fix = -c_fix; sn_fix = -s_fix; end
            default: begin cs_fix = s_fix;  sn_fix = -c_fix; end
        endcase
        n4 = acc_reg[4] + acc_reg[6];
        n5 = acc_reg[5] + acc_reg[7];
    end

    function automatic logic signed [31:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // sequencer, datapath registers and matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            mat_reg[0]     <= DW'(atc_pkg::ONE_FIX);
            mat_reg[1]     <= '0;
            mat_reg[2]     <= '0;
            mat_reg[3]     <= DW'(atc_pkg::ONE_FIX);
            mat_reg[4]     <= '0;
            mat_reg[5]     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cx_reg <= center_x;
                        cy_reg <= center_y;
                        for (int i = 0; i < 6; i++)
                            acc_reg[i] <= '0;
                        // translate seeds the translation terms with the offset
                        acc_reg[6] <= (func == atc_pkg::FUNC_TRANSLATE) ? ACC_W'(shift_x)
                                                                        : '0;
                        acc_reg[7] <= (func == atc_pkg::FUNC_TRANSLATE) ? ACC_W'(shift_y)
                                                                        : '0;
                        pend_valid_reg <= 1'b0;
                        cnt_reg <= '0;
                        t_reg[1] <= '0;
                        t_reg[2] <= '0;
                        sn_reg   <= '0;
                        case (func)
                            atc_pkg::FUNC_ROTATE:
                            begin
                                rem_reg   <= RED_W'({~angle_deg[31], angle_deg[30:0]});
                                cnt_reg   <= RED_LAST;
                                state_reg <= S_REDUCE;
                            end
                            atc_pkg::FUNC_SCALE:
                            begin
                                t_reg[0]  <= OP_W'(scale_factor);
                                t_reg[3]  <= OP_W'(scale_factor);
                                omc_reg   <= ONE_OP - OP_W'(scale_factor);
                                state_reg <= S_MAC;
                            end
                            atc_pkg::FUNC_TRANSLATE:
                            begin
                                t_reg[0]   <= ONE_OP;
                                t_reg[3]   <= ONE_OP;
                                omc_reg    <= '0;
                                state_reg  <= S_MAC;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                        endcase
                    end
                end
                S_REDUCE:
                begin
                    if (rem_reg >= red_sub)
                        rem_reg <= rem_reg - red_sub;
                    if (cnt_reg == '0)
                        state_reg <= S_WRAP;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                S_WRAP:
                begin
                    z_reg     <= Z_W'(wrapped) <<< (atc_pkg::ANG_FRAC - FB);
                    q_reg     <= '0;
                    state_reg <= S_QUAD;
                end
                S_QUAD:
                begin
                    if (z_reg >= QUARTER_Z)
                    begin
                        z_reg <= z_reg - QUARTER_Z;
                        q_reg <= q_reg + 1'b1;
                    end
                    else
                    begin
                        x_reg     <= XY_W'(atc_pkg::CORDIC_GAIN);
                        y_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (!z_reg[Z_W-1])
                    begin
                        x_reg <= x_reg - (y_reg >>> cnt_reg);
                        y_reg <= y_reg + (x_reg >>> cnt_reg);
                        z_reg <= z_reg - signed'(atc_pkg::atan_deg(cnt_reg));
                    end
                    else
                    begin
                        x_reg <= x_reg + (y_reg >>> cnt_reg);
                        y_reg <= y_reg - (x_reg >>> cnt_reg);
                        z_reg <= z_reg + signed'(atc_pkg::atan_deg(cnt_reg));
                    end
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= S_ROUND;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_ROUND:
                begin
                    t_reg[0]  <= cs_fix;
                    t_reg[1]  <= sn_fix;
                    t_reg[2]  <= -sn_fix;
                    t_reg[3]  <= cs_fix;
                    omc_reg   <= ONE_OP - cs_fix;
                    sn_reg    <= sn_fix;
                    cnt_reg   <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (pend_valid_reg)
                        acc_reg[pend_dst_reg] <= pend_sub_reg ? acc_reg[pend_dst_reg] - rnd
                                                              : acc_reg[pend_dst_reg] + rnd;
                    pend_valid_reg <= 1'b1;
                    pend_dst_reg   <= mul_dst;
                    pend_sub_reg   <= mul_sub;
                    if (cnt_reg == MAC_LAST)
                        state_reg <= S_DRAIN;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    acc_reg[pend_dst_reg] <= pend_sub_reg ? acc_reg[pend_dst_reg] - rnd
                                                          : acc_reg[pend_dst_reg] + rnd;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= S_SAT;
                end
                S_SAT:
                begin
                    for (int i = 0; i < 4; i++)
                        mat_reg[i] <= sat(acc_reg[i]);
                    mat_reg[4]    <= sat(n4);
                    mat_reg[5]    <= sat(n5);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/atc_check.sv]
`default_nettype none
module atc_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] m_xx,
    input wire logic signed [31:0] m_tx
);

    // a request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after request accept");

    // never ready for a request while a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    // taking the result frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("not idle after result taken");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m_xx) && $stable(m_tx))
        else $error("result changed while stalled");

endmodule

bind affine_transform_accumulator atc_check u_atc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .m_xx      (m_xx),
    .m_tx      (m_tx)
);
`default_nettype wire
